// File: rtl/core/sorted_list_insert_remove_unit_assert.svh
// ---------------------------------------------------------------------------
// sorted list unit assertion macros
// shared property templates, clocked on clk and disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_REMOVE_UNIT_ASSERT_SVH
`define SORTED_LIST_INSERT_REMOVE_UNIT_ASSERT_SVH

// same-cycle implication
`define SLIR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slir assertion failed");

// next-cycle implication
`define SLIR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slir assertion failed");

`endif

// File: rtl/core/slir_pkg.sv
// ---------------------------------------------------------------------------
// slir_pkg
// shared codes, defaults and control types of the sorted list unit
// ---------------------------------------------------------------------------
package slir_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    // action codes
    localparam logic [1:0] ACT_INSERT   = 2'd0;
    localparam logic [1:0] ACT_REMOVE   = 2'd1;
    localparam logic [1:0] ACT_DUMP     = 2'd2;
    localparam logic [1:0] ACT_RESERVED = 2'd3;   // ignored, no result

    // status codes
    localparam logic [1:0] STAT_DONE      = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_DUMP      = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic       load;       // capture value, clear dump index
        logic       compare;    // register per-cell compare results
        logic       do_insert;
        logic       do_remove;
        logic       rotate;     // dump step: cell 0 goes to the tail
        logic       emit;       // launch one result
        logic [1:0] code;
        logic       last;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic found;
        logic dump_last;
    } stat_t;

endpackage

// File: rtl/core/slir_ctrl.sv
// ---------------------------------------------------------------------------
// slir_ctrl
// transaction sequencer: accept, compare, update, and dump walk
// ---------------------------------------------------------------------------
module slir_ctrl
    import slir_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] action,
    input  stat_t      stat,
    output logic       busy,
    output cmd_t       cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;
    localparam logic [1:0] ST_DUMP = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic [1:0] action_reg;
    logic [1:0] action_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            action_reg <= ACT_INSERT;
        end
        else
        begin
            state_reg  <= state_next;
            action_reg <= action_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        action_next = action_reg;
        cmd         = '0;
        cmd.code    = STAT_DONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (action)
                        ACT_INSERT, ACT_REMOVE:
                        begin
                            cmd.load    = 1'b1;
                            action_next = action;
                            state_next  = ST_CMP;
                        end
                        ACT_DUMP:
                        begin
                            // empty table dumps nothing
                            if (!stat.empty)
                            begin
                                cmd.load   = 1'b1;
                                state_next = ST_DUMP;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CMP:
            begin
                cmd.compare = 1'b1;
                state_next  = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.emit = 1'b1;
                cmd.last = 1'b1;
                if (action_reg == ACT_INSERT)
                begin
                    if (stat.full)
                        cmd.code = STAT_FULL;
                    else
                        cmd.do_insert = 1'b1;
                end
                else
                begin
                    if (stat.found)
                        cmd.do_remove = 1'b1;
                    else
                        cmd.code = STAT_NOT_FOUND;
                end
                state_next = ST_IDLE;
            end
            ST_DUMP:
            begin
                cmd.rotate = 1'b1;
                cmd.emit   = 1'b1;
                cmd.code   = STAT_DUMP;
                cmd.last   = stat.dump_last;
                if (stat.dump_last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/slir_dp.sv
// ---------------------------------------------------------------------------
// slir_dp
// row of compare-and-shift cells, entry count and result registers
// ---------------------------------------------------------------------------
`include "sorted_list_insert_remove_unit_assert.svh"

module slir_dp
    import slir_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic signed [31:0] value,
    input  cmd_t               cmd,
    output stat_t              stat,
    output logic               strobe,
    output logic [1:0]         status,
    output logic signed [31:0] entry_value,
    output logic               last
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic signed [31:0] entries_reg [TABLE_DEPTH];
    logic signed [31:0] entries_next [TABLE_DEPTH];
    logic signed [31:0] ent_dn [TABLE_DEPTH];   // left neighbor, value at the head
    logic signed [31:0] ent_up [TABLE_DEPTH];   // right neighbor, head at the tail
    logic [TABLE_DEPTH-1:0] gt_prev;

    logic signed [31:0] value_reg;
    logic [TABLE_DEPTH-1:0] gt_reg;
    logic [TABLE_DEPTH-1:0] gt_next;
    logic [TABLE_DEPTH-1:0] eq_reg;
    logic [TABLE_DEPTH-1:0] eq_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] dump_idx_reg;
    logic [CNT_W-1:0] dump_idx_next;

    logic               strobe_reg;
    logic [1:0]         status_reg;
    logic signed [31:0] entry_value_reg;
    logic               last_reg;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_nbr
            if (g == 0)
            begin : g_head
                assign ent_dn[g]  = value_reg;
                assign gt_prev[g] = 1'b1;
            end
            else
            begin : g_body
                assign ent_dn[g]  = entries_reg[g-1];
                assign gt_prev[g] = gt_reg[g-1];
            end
            if (g == TABLE_DEPTH - 1)
            begin : g_tail
                assign ent_up[g] = entries_reg[0];
            end
            else
            begin : g_inner
                assign ent_up[g] = entries_reg[g+1];
            end
        end
    endgenerate

    // per-cell compare; sorted order makes gt a prefix of the live cells
    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            gt_next[i] = (CNT_W'(i) < count_reg) && (value_reg > entries_reg[i]);
            eq_next[i] = (CNT_W'(i) < count_reg) && (value_reg == entries_reg[i]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            entries_next[i] = entries_reg[i];
            if (cmd.do_insert && !gt_reg[i])
                entries_next[i] = gt_prev[i] ? value_reg : ent_dn[i];
            else if (cmd.do_remove && !gt_reg[i])
                entries_next[i] = ent_up[i];
            else if (cmd.rotate)
                entries_next[i] = (count_reg == CNT_W'(i + 1)) ? entries_reg[0] : ent_up[i];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.do_insert)
            count_next = count_reg + CNT_W'(1);
        else if (cmd.do_remove)
            count_next = count_reg - CNT_W'(1);
    end

    always_comb
    begin
        dump_idx_next = dump_idx_reg;
        if (cmd.load)
            dump_idx_next = '0;
        else if (cmd.rotate)
            dump_idx_next = dump_idx_reg + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            dump_idx_reg <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            dump_idx_reg <= dump_idx_next;
            strobe_reg   <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        entries_reg <= entries_next;
        if (cmd.load)
            value_reg <= value;
        if (cmd.compare)
        begin
            gt_reg <= gt_next;
            eq_reg <= eq_next;
        end
        if (cmd.emit)
        begin
            status_reg      <= cmd.code;
            entry_value_reg <= (cmd.code == STAT_DUMP) ? entries_reg[0] : 32'sd0;
            last_reg        <= cmd.last;
        end
    end

    assign stat.full      = (count_reg == CNT_W'(TABLE_DEPTH));
    assign stat.empty     = (count_reg == '0);
    assign stat.found     = |eq_reg;
    assign stat.dump_last = ((dump_idx_reg + CNT_W'(1)) == count_reg);

    assign strobe      = strobe_reg;
    assign status      = status_reg;
    assign entry_value = entry_value_reg;
    assign last        = last_reg;

    `SLIR_ASSERT_SAME(a_count_range, 1'b1, count_reg <= CNT_W'(TABLE_DEPTH))
    `SLIR_ASSERT_SAME(a_insert_not_full, cmd.do_insert, !stat.full)
    `SLIR_ASSERT_SAME(a_remove_found, cmd.do_remove, stat.found && !stat.empty)
    `SLIR_ASSERT_SAME(a_rotate_in_range, cmd.rotate, dump_idx_reg < count_reg)
    `SLIR_ASSERT_NEXT(a_insert_count, cmd.do_insert,
                      count_reg == $past(count_reg) + CNT_W'(1))

endmodule

// File: rtl/core/sorted_list_insert_remove_unit.sv
// ---------------------------------------------------------------------------
// sorted_list_insert_remove_unit
// bounded ascending table of signed 32-bit values with insert, remove, dump
// ---------------------------------------------------------------------------
// channel   handshake            payload
// command   start, busy          action, value
// result    strobe (one cycle)   status, entry_value, last
//
// insert and remove: the accept, compare and update states pass before the next
//   possible accept; the result appears in the cycle after the update
// dump: after the accept, one result a cycle for each stored entry, as cell 0
//   is read and the live entries rotate
// reset clears the entry count, dump index and strobe; table cells are written before use
// results cannot be stalled; a new command may be taken while one is shown
// ---------------------------------------------------------------------------
module sorted_list_insert_remove_unit
    import slir_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         action,
    input  logic signed [31:0] value,
    output logic               strobe,
    output logic [1:0]         status,
    output logic signed [31:0] entry_value,
    output logic               last
);

    cmd_t  cmd;
    stat_t stat;

    slir_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .stat   (stat),
        .busy   (busy),
        .cmd    (cmd)
    );

    slir_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .cmd         (cmd),
        .stat        (stat),
        .strobe      (strobe),
        .status      (status),
        .entry_value (entry_value),
        .last        (last)
    );

endmodule
